// ===== src/bor_pkg.sv =====
`timescale 1ns / 1ps

package bor_pkg;

  localparam int COORD_W = 13;
  localparam int SIZE_W  = 12;
  localparam int FRAC_W  = 16;

  // corner plus size, one extra bit for sign headroom
  localparam int EDGE_W  = ((COORD_W > SIZE_W + 1) ? COORD_W : SIZE_W + 1) + 1;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int DEN_W   = AREA_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int QUO_W   = FRAC_W + 1;

  localparam logic [QUO_W-1:0] FRAC_ONE = QUO_W'(1) << FRAC_W;

  // configuration register map
  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_OVERLAP_MODE = 1'b0;

  typedef enum logic {
    MODE_UNION = 1'b0,
    MODE_MIN   = 1'b1
  } bor_mode_t;

  // beat carried down the divider chain
  typedef struct packed {
    logic [DEN_W-1:0]  den;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
    logic [AREA_W-1:0] inter;
    logic              zero;
  } bor_div_t;

endpackage

// ===== src/bor_geom.sv =====
`timescale 1ns / 1ps

module bor_geom (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              vld_i,
  input  bor_pkg::bor_mode_t                mode,
  input  logic signed [bor_pkg::COORD_W-1:0] a_left,
  input  logic signed [bor_pkg::COORD_W-1:0] a_top,
  input  logic        [bor_pkg::SIZE_W-1:0]  a_width,
  input  logic        [bor_pkg::SIZE_W-1:0]  a_height,
  input  logic signed [bor_pkg::COORD_W-1:0] b_left,
  input  logic signed [bor_pkg::COORD_W-1:0] b_top,
  input  logic        [bor_pkg::SIZE_W-1:0]  b_width,
  input  logic        [bor_pkg::SIZE_W-1:0]  b_height,
  output logic                              vld_o,
  output bor_pkg::bor_div_t                 beat_o
);

  localparam int EW = bor_pkg::EDGE_W;
  localparam int SW = bor_pkg::SIZE_W;
  localparam int AW = bor_pkg::AREA_W;
  localparam int DW = bor_pkg::DEN_W;

  logic [2:0] vld_r;
  logic       vld4_r;

  // stage 1: overlap bounds per axis
  logic signed [EW-1:0] a_l, a_r, b_l, b_r, a_t, a_b, b_t, b_b;
  logic signed [EW-1:0] lo_x_nxt, hi_x_nxt, lo_y_nxt, hi_y_nxt;
  logic signed [EW-1:0] lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic [SW-1:0] aw1_r, ah1_r, bw1_r, bh1_r;

  // stage 2: clamped extents
  logic signed [EW:0] dx, dy;
  logic [SW-1:0] iw_nxt, ih_nxt, iw_r, ih_r;
  logic [SW-1:0] aw2_r, ah2_r, bw2_r, bh2_r;

  // stage 3: areas
  logic [AW-1:0] inter_r, area_a_r, area_b_r;

  // stage 4: denominator
  logic [DW-1:0] den_nxt;
  bor_pkg::bor_div_t beat_r;

  always_comb begin
    a_l = EW'(a_left);
    a_r = EW'(a_left) + EW'($signed({1'b0, a_width}));
    b_l = EW'(b_left);
    b_r = EW'(b_left) + EW'($signed({1'b0, b_width}));
    a_t = EW'(a_top);
    a_b = EW'(a_top) + EW'($signed({1'b0, a_height}));
    b_t = EW'(b_top);
    b_b = EW'(b_top) + EW'($signed({1'b0, b_height}));
    lo_x_nxt = (a_l > b_l) ? a_l : b_l;
    hi_x_nxt = (a_r < b_r) ? a_r : b_r;
    lo_y_nxt = (a_t > b_t) ? a_t : b_t;
    hi_y_nxt = (a_b < b_b) ? a_b : b_b;
  end

  always_comb begin
    dx = (EW+1)'(hi_x_r) - (EW+1)'(lo_x_r);
    dy = (EW+1)'(hi_y_r) - (EW+1)'(lo_y_r);
    // overlap never exceeds the narrower box, so it fits the size width
    iw_nxt = (dx > 0) ? dx[SW-1:0] : '0;
    ih_nxt = (dy > 0) ? dy[SW-1:0] : '0;
  end

  always_comb begin
    unique case (mode)
      bor_pkg::MODE_MIN:
        den_nxt = (area_a_r < area_b_r) ? DW'(area_a_r) : DW'(area_b_r);
      default:
        den_nxt = DW'(area_a_r) + DW'(area_b_r) - DW'(inter_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= {vld_r[1:0], vld_i};
      vld4_r <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_x_r   <= lo_x_nxt;
      hi_x_r   <= hi_x_nxt;
      lo_y_r   <= lo_y_nxt;
      hi_y_r   <= hi_y_nxt;
      aw1_r    <= a_width;
      ah1_r    <= a_height;
      bw1_r    <= b_width;
      bh1_r    <= b_height;

      iw_r     <= iw_nxt;
      ih_r     <= ih_nxt;
      aw2_r    <= aw1_r;
      ah2_r    <= ah1_r;
      bw2_r    <= bw1_r;
      bh2_r    <= bh1_r;

      inter_r  <= AW'(iw_r) * AW'(ih_r);
      area_a_r <= AW'(aw2_r) * AW'(ah2_r);
      area_b_r <= AW'(bw2_r) * AW'(bh2_r);

      beat_r.den   <= den_nxt;
      beat_r.rem   <= bor_pkg::REM_W'(inter_r);
      beat_r.quo   <= '0;
      beat_r.inter <= inter_r;
      beat_r.zero  <= (den_nxt == '0);
    end
  end

  assign vld_o  = vld4_r;
  assign beat_o = beat_r;

endmodule

// ===== src/bor_div_cell.sv =====
`timescale 1ns / 1ps

module bor_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  bor_pkg::bor_div_t beat_i,
  output logic              vld_o,
  output bor_pkg::bor_div_t beat_o
);

  localparam int RW = bor_pkg::REM_W;
  localparam int QW = bor_pkg::QUO_W;

  logic          q;
  logic [RW-1:0] diff, rem_kept;
  logic          vld_r;
  bor_pkg::bor_div_t beat_r;

  // restoring step: one quotient bit, remainder doubled for the next cell
  always_comb begin
    q        = (beat_i.rem >= RW'(beat_i.den));
    diff     = beat_i.rem - RW'(beat_i.den);
    rem_kept = q ? diff : beat_i.rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r.den   <= beat_i.den;
      beat_r.rem   <= {rem_kept[RW-2:0], 1'b0};
      beat_r.quo   <= {beat_i.quo[QW-2:0], q};
      beat_r.inter <= beat_i.inter;
      beat_r.zero  <= beat_i.zero;
    end
  end

  assign vld_o  = vld_r;
  assign beat_o = beat_r;

endmodule

// ===== src/box_overlap_ratio_unit.sv =====
`timescale 1ns / 1ps

// Box overlap ratio (IoU) of two axis-aligned boxes, one pair per beat.
// Boxes use the exclusive convention: [left, left+width) x [top, top+height),
// area = width*height. The result is intersection * 2^16 / denominator,
// rounded down, where the denominator is the union area (overlap_mode 0) or
// the smaller box area (overlap_mode 1). A zero denominator sets
// zero_denominator and forces the fraction to 0. Throughput is one box pair
// per clock while in_stall is low; an input beat passes through four
// geometry stages (bounds, extents, area multiplies, denominator), a chain of
// 17 divider cells that each retire one quotient bit, and the output
// register. A skid register behind the output lets a result wait while the
// next beat is still taken; in_stall rises only once both are full.
// Write overlap_mode at byte address 0 over the APB port while idle.

module box_overlap_ratio_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bor_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bor_pkg::COORD_W-1:0] in_a_left,
  input  logic signed [bor_pkg::COORD_W-1:0] in_a_top,
  input  logic        [bor_pkg::SIZE_W-1:0]  in_a_width,
  input  logic        [bor_pkg::SIZE_W-1:0]  in_a_height,
  input  logic signed [bor_pkg::COORD_W-1:0] in_b_left,
  input  logic signed [bor_pkg::COORD_W-1:0] in_b_top,
  input  logic        [bor_pkg::SIZE_W-1:0]  in_b_width,
  input  logic        [bor_pkg::SIZE_W-1:0]  in_b_height,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bor_pkg::QUO_W-1:0]          out_overlap_fraction,
  output logic [bor_pkg::AREA_W-1:0]         out_intersection_area,
  output logic                               out_zero_denominator
);

  localparam int NCELL = bor_pkg::QUO_W;

  bor_pkg::bor_mode_t mode_r;

  // pipeline advances while the skid register is free
  logic adv;

  logic              vld_chain  [NCELL+1];
  bor_pkg::bor_div_t beat_chain [NCELL+1];

  logic                       out_vld_r, skid_vld_r;
  logic [bor_pkg::QUO_W-1:0]  tail_frac;
  logic [bor_pkg::QUO_W-1:0]  out_frac_r, skid_frac_r;
  logic [bor_pkg::AREA_W-1:0] out_inter_r, skid_inter_r;
  logic                       out_zero_r, skid_zero_r;
  logic                       tail_vld, out_free;

  // ---- configuration port ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= bor_pkg::MODE_UNION;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == bor_pkg::REG_OVERLAP_MODE)) begin
      mode_r <= bor_pkg::bor_mode_t'(pwdata[0]);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bor_pkg::REG_OVERLAP_MODE) ? {31'd0, mode_r} : 32'd0;

  // ---- geometry front end ----
  assign adv      = !skid_vld_r;
  assign in_stall = skid_vld_r;

  bor_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .vld_i    (in_valid),
    .mode     (mode_r),
    .a_left   (in_a_left),
    .a_top    (in_a_top),
    .a_width  (in_a_width),
    .a_height (in_a_height),
    .b_left   (in_b_left),
    .b_top    (in_b_top),
    .b_width  (in_b_width),
    .b_height (in_b_height),
    .vld_o    (vld_chain[0]),
    .beat_o   (beat_chain[0])
  );

  // ---- divider chain: one quotient bit per cell, MSB first ----
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    bor_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .vld_i  (vld_chain[i]),
      .beat_i (beat_chain[i]),
      .vld_o  (vld_chain[i+1]),
      .beat_o (beat_chain[i+1])
    );
  end

  assign tail_vld  = vld_chain[NCELL] && adv;
  // zero denominator leaves an all-ones quotient; mask it
  assign tail_frac = beat_chain[NCELL].zero ? '0 : beat_chain[NCELL].quo;
  assign out_free  = !out_vld_r || !out_stall;

  // ---- output register plus skid ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r  <= skid_vld_r || tail_vld;
      skid_vld_r <= 1'b0;
    end else if (tail_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_vld_r) begin
        out_frac_r  <= skid_frac_r;
        out_inter_r <= skid_inter_r;
        out_zero_r  <= skid_zero_r;
      end else begin
        out_frac_r  <= tail_frac;
        out_inter_r <= beat_chain[NCELL].inter;
        out_zero_r  <= beat_chain[NCELL].zero;
      end
    end else if (tail_vld) begin
      skid_frac_r  <= tail_frac;
      skid_inter_r <= beat_chain[NCELL].inter;
      skid_zero_r  <= beat_chain[NCELL].zero;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_overlap_fraction  = out_frac_r;
  assign out_intersection_area = out_inter_r;
  assign out_zero_denominator  = out_zero_r;

  // ---- checks ----
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && out_stall))
    else $error("skid filled without a stalled output");

  a_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_zero_r) |-> (out_frac_r == '0))
    else $error("zero denominator with nonzero fraction");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_frac_r <= bor_pkg::FRAC_ONE))
    else $error("overlap fraction above one");

endmodule
